[design/pattern_class_mask_encoder_macros.svh]
`ifndef PATTERN_CLASS_MASK_ENCODER_MACROS_SVH
`define PATTERN_CLASS_MASK_ENCODER_MACROS_SVH

// Property that must hold at every clock edge out of reset
`define PCME_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define PCME_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define PCME_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/pcme_pkg.sv]
`default_nettype none

package pcme_pkg;

  localparam int unsigned MAX_POSITIONS = 32;
  localparam int unsigned CNT_W         = $clog2(MAX_POSITIONS + 1);
  localparam int unsigned CFG_IDX_W     = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEGATE_MASK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REQUIRED_MARK = 2'd2;

  // Alphabet table modes
  localparam logic [1:0] TBL_DNA  = 2'd1;
  localparam logic [1:0] TBL_PROT = 2'd2;

  localparam logic [31:0] NEGATE_MASK_RST   = 32'h03ff_ffff;
  localparam logic [31:0] REQUIRED_MARK_RST = 32'h8000_0000;

  // Pattern syntax characters
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_Z    = 8'h5a;
  localparam logic [7:0] CH_LBR  = 8'h5b;
  localparam logic [7:0] CH_RBR  = 8'h5d;

  typedef struct packed {
    logic [7:0] char_in;
    logic       final_char;
  } pcme_in_t;

  typedef struct packed {
    logic [31:0] position_code;
    logic [4:0]  position_index;
    logic [5:0]  pattern_length;
    logic        syntax_error;
    logic        final_result;
  } pcme_out_t;

  typedef struct packed {
    logic [1:0]  table_mode;
    logic [31:0] negate_mask;
    logic [31:0] required_mark;
  } pcme_cfg_t;

  // Up to two results produced by one character, a first
  typedef struct packed {
    logic [1:0] cnt;
    pcme_out_t  a;
    pcme_out_t  b;
  } pcme_push_t;

  function automatic logic [31:0] dna_mask(input logic [4:0] idx);
    logic [31:0] m;
    case (idx)
      5'd0:    m = 32'h0000_0001;
      5'd1:    m = 32'h0008_0044;
      5'd2:    m = 32'h0000_0004;
      5'd3:    m = 32'h0008_0041;
      5'd6:    m = 32'h0000_0040;
      5'd7:    m = 32'h0008_0005;
      5'd10:   m = 32'h0008_0040;
      5'd12:   m = 32'h0000_0005;
      5'd13:   m = 32'h0008_0045;
      5'd17:   m = 32'h0000_0041;
      5'd18:   m = 32'h0000_0044;
      5'd19:   m = 32'h0008_0000;
      5'd20:   m = 32'h0008_0000;
      5'd21:   m = 32'h0000_0045;
      5'd22:   m = 32'h0008_0001;
      5'd23:   m = 32'h0008_0045;
      5'd24:   m = 32'h0008_0004;
      default: m = 32'h0000_0000;
    endcase
    return m;
  endfunction

  function automatic logic [31:0] prot_mask(input logic [4:0] idx);
    logic [31:0] m;
    case (idx)
      5'd1:    m = 32'h0000_2008;
      5'd9:    m = 32'h0000_0000;
      5'd14:   m = 32'h0000_0000;
      5'd20:   m = 32'h0000_0000;
      5'd23:   m = 32'h037f_ffff;
      5'd25:   m = 32'h0001_0010;
      default: m = 32'h0000_0001 << idx;
    endcase
    return m;
  endfunction

  function automatic logic [31:0] letter_mask(input logic [1:0] mode, input logic [4:0] idx);
    logic [31:0] m;
    case (mode)
      TBL_DNA:  m = dna_mask(idx);
      TBL_PROT: m = prot_mask(idx);
      default:  m = 32'h0000_0001 << idx;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

[design/pattern_class_mask_encoder.sv]
// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall  in_data   (char_in, final_char)
// out_     output     out_valid/ out_stall out_data  (position code, index, length, flags)
// cfg_     input      cfg_valid/ cfg_ready cfg_index, cfg_data
//
// One character is taken per cycle while in_stall is low; its results are registered into the output queue.
// Results leave from a three-entry output queue; in_stall is high while two or more wait.
// A character that closes a pattern may yield two results, so the queue absorbs the burst.
// Synchronous reset clears pattern state and restores register defaults.
// cfg_ready is always high; writes take effect on the next character.
`default_nettype none

module pattern_class_mask_encoder (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire pcme_pkg::pcme_in_t                   in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output pcme_pkg::pcme_out_t                       out_data,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [pcme_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [31:0]                          cfg_data
);
  import pcme_pkg::*;

  logic        [1:0]  table_mode_r;
  logic        [31:0] negate_mask_r;
  logic        [31:0] required_mark_r;
  pcme_cfg_t          cfg;
  pcme_push_t         push;
  logic               in_acc;
  logic               busy;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign in_acc    = in_valid && !in_stall;
  assign cfg       = '{table_mode:    table_mode_r,
                       negate_mask:   negate_mask_r,
                       required_mark: required_mark_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_mode_r    <= 2'd0;
      negate_mask_r   <= NEGATE_MASK_RST;
      required_mark_r <= REQUIRED_MARK_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TABLE_MODE:    table_mode_r    <= cfg_data[1:0];
        REG_NEGATE_MASK:   negate_mask_r   <= cfg_data;
        REG_REQUIRED_MARK: required_mark_r <= cfg_data;
        default: ;
      endcase
    end
  end

  pcme_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_acc  (in_acc),
    .in_data (in_data),
    .cfg     (cfg),
    .push    (push)
  );

  pcme_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[design/pcme_step.sv]
`default_nettype none
`include "pattern_class_mask_encoder_macros.svh"

module pcme_step (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_acc,
  input  wire pcme_pkg::pcme_in_t in_data,
  input  wire pcme_pkg::pcme_cfg_t cfg,
  output pcme_pkg::pcme_push_t    push
);
  import pcme_pkg::*;

  logic             pend_v_r, pend_v_nxt;
  logic [31:0]      pend_code_r, pend_code_nxt;
  logic             parity_r, parity_nxt;
  logic             in_class_r, in_class_nxt;
  logic             just_opened_r, just_opened_nxt;
  logic             bang_r, bang_nxt;
  logic             at_start_r, at_start_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             err_r, err_nxt;

  logic             is_letter;
  logic [31:0]      lmask;
  logic [31:0]      neg_letter, neg_zero, neg_pend;
  logic             f0;
  logic [31:0]      f0_code;
  logic             e0_v, e1_v, f1;
  logic [CNT_W-1:0] cnt1;
  logic             fin;
  pcme_out_t        res0, res1, res_stat;

  function automatic logic [31:0] apply_neg(input logic [31:0] v, input logic bang,
                                            input logic par, input logic [31:0] nm);
    logic [31:0] r;
    r = v;
    if (bang) begin
      r = par ? (~v & nm) : (v & nm);
    end
    return r;
  endfunction

  assign is_letter  = (in_data.char_in >= CH_A) && (in_data.char_in <= CH_Z);
  assign lmask      = letter_mask(cfg.table_mode, 5'(in_data.char_in - CH_A));
  assign neg_letter = apply_neg(lmask, bang_r, parity_r, cfg.negate_mask);
  assign neg_zero   = apply_neg(32'h0, bang_r, parity_r, cfg.negate_mask);
  assign neg_pend   = apply_neg(pend_code_r, bang_r, parity_r, cfg.negate_mask);
  assign fin        = in_data.final_char;

  always_comb begin
    pend_v_nxt      = pend_v_r;
    pend_code_nxt   = pend_code_r;
    parity_nxt      = parity_r;
    in_class_nxt    = in_class_r;
    just_opened_nxt = just_opened_r;
    bang_nxt        = bang_r;
    cnt_nxt         = cnt_r;
    err_nxt         = err_r;
    f0              = 1'b0;
    f0_code         = pend_code_r;

    case (in_data.char_in)
      CH_HASH: begin
        if (at_start_r || in_class_r) begin
          err_nxt = 1'b1;
        end
        if (!in_class_r) begin
          if (pend_v_r) begin
            f0            = 1'b1;
            f0_code       = pend_code_r | cfg.required_mark;
            pend_v_nxt    = 1'b0;
            pend_code_nxt = 32'h0;
          end else begin
            // stray mark: empty letter set, negation applied
            pend_code_nxt = neg_zero | cfg.required_mark;
            pend_v_nxt    = 1'b1;
            bang_nxt      = 1'b0;
            parity_nxt    = 1'b0;
          end
        end
      end
      CH_LBR: begin
        if (in_class_r) begin
          err_nxt = 1'b1;
        end else begin
          f0              = pend_v_r;
          pend_v_nxt      = 1'b0;
          pend_code_nxt   = 32'h0;
          in_class_nxt    = 1'b1;
          just_opened_nxt = 1'b1;
        end
      end
      CH_RBR: begin
        if (!in_class_r) begin
          err_nxt = 1'b1;
        end else begin
          if (just_opened_r) begin
            err_nxt = 1'b1;
          end
          in_class_nxt    = 1'b0;
          just_opened_nxt = 1'b0;
          pend_code_nxt   = neg_pend;
          pend_v_nxt      = 1'b1;
          bang_nxt        = 1'b0;
          parity_nxt      = 1'b0;
        end
      end
      CH_BANG: begin
        if (in_class_r) begin
          err_nxt = 1'b1;
        end else begin
          f0            = pend_v_r;
          pend_v_nxt    = 1'b0;
          pend_code_nxt = 32'h0;
          bang_nxt      = 1'b1;
          parity_nxt    = !parity_r;
        end
      end
      default: begin
        if (!is_letter) begin
          err_nxt = 1'b1;
        end else if (in_class_r) begin
          pend_code_nxt   = pend_code_r | lmask;
          just_opened_nxt = 1'b0;
        end else begin
          f0            = pend_v_r;
          pend_code_nxt = neg_letter;
          pend_v_nxt    = 1'b1;
          bang_nxt      = 1'b0;
          parity_nxt    = 1'b0;
        end
      end
    endcase
    at_start_nxt = 1'b0;

    // Drop positions beyond the limit and flag them
    e0_v = f0 && (cnt_r < CNT_W'(MAX_POSITIONS));
    if (f0 && !e0_v) begin
      err_nxt = 1'b1;
    end
    cnt1 = cnt_r + CNT_W'(e0_v);

    f1   = 1'b0;
    e1_v = 1'b0;
    if (fin) begin
      if (in_class_nxt || bang_nxt) begin
        err_nxt = 1'b1;
      end
      f1   = pend_v_nxt;
      e1_v = f1 && (cnt1 < CNT_W'(MAX_POSITIONS));
      if (f1 && !e1_v) begin
        err_nxt = 1'b1;
      end
    end

    res0 = '{position_code:  f0_code,
             position_index: 5'(cnt_r),
             pattern_length: 6'(cnt_r + CNT_W'(1)),
             syntax_error:   1'b0,
             final_result:   1'b0};
    res1 = '{position_code:  pend_code_nxt,
             position_index: 5'(cnt1),
             pattern_length: 6'(cnt1 + CNT_W'(1)),
             syntax_error:   1'b0,
             final_result:   1'b0};
    res_stat = '{position_code:  32'h0,
                 position_index: 5'd0,
                 pattern_length: 6'(cnt1),
                 syntax_error:   1'b0,
                 final_result:   1'b0};

    push.cnt = 2'd0;
    push.a   = res0;
    push.b   = res1;
    if (!fin) begin
      push.cnt = {1'b0, e0_v};
    end else if (e0_v && e1_v) begin
      push.cnt                = 2'd2;
      push.b.syntax_error     = err_nxt;
      push.b.final_result     = 1'b1;
    end else begin
      push.cnt = 2'd1;
      if (!e0_v) begin
        push.a = e1_v ? res1 : res_stat;
      end
      push.a.syntax_error = err_nxt;
      push.a.final_result = 1'b1;
    end
    if (!in_acc) begin
      push.cnt = 2'd0;
    end

    cnt_nxt = cnt1 + CNT_W'(e1_v);

    // End of pattern: back to the reset state
    if (fin) begin
      pend_v_nxt      = 1'b0;
      pend_code_nxt   = 32'h0;
      parity_nxt      = 1'b0;
      in_class_nxt    = 1'b0;
      just_opened_nxt = 1'b0;
      bang_nxt        = 1'b0;
      at_start_nxt    = 1'b1;
      cnt_nxt         = '0;
      err_nxt         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r      <= 1'b0;
      pend_code_r   <= 32'h0;
      parity_r      <= 1'b0;
      in_class_r    <= 1'b0;
      just_opened_r <= 1'b0;
      bang_r        <= 1'b0;
      at_start_r    <= 1'b1;
      cnt_r         <= '0;
      err_r         <= 1'b0;
    end else if (in_acc) begin
      pend_v_r      <= pend_v_nxt;
      pend_code_r   <= pend_code_nxt;
      parity_r      <= parity_nxt;
      in_class_r    <= in_class_nxt;
      just_opened_r <= just_opened_nxt;
      bang_r        <= bang_nxt;
      at_start_r    <= at_start_nxt;
      cnt_r         <= cnt_nxt;
      err_r         <= err_nxt;
    end
  end

  `PCME_ASSERT_NEXT(a_final_clears, in_acc && in_data.final_char, at_start_r && !pend_v_r && (cnt_r == '0), "pattern state not cleared after final character")
  `PCME_ASSERT(a_class_no_pending, !in_class_r || !pend_v_r, "pending position held inside a class")
  `PCME_ASSERT_IMPLY(a_error_only_final, (push.cnt != 2'd0) && push.a.syntax_error, push.a.final_result, "error flag on a result that is not final")

endmodule

`default_nettype wire

[design/pcme_outq.sv]
`default_nettype none
`include "pattern_class_mask_encoder_macros.svh"

module pcme_outq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire pcme_pkg::pcme_push_t push,
  output logic                      busy,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output pcme_pkg::pcme_out_t       out_data
);
  import pcme_pkg::*;

  pcme_out_t  q_r [3];
  pcme_out_t  q_nxt [3];
  pcme_out_t  sh [3];
  logic [1:0] occ_r, occ_nxt, occ_p;
  logic       pop;

  assign out_valid = (occ_r != 2'd0);
  assign out_data  = q_r[0];
  assign pop       = out_valid && !out_stall;
  // Room for a character that may yield two results
  assign busy      = (occ_r >= 2'd2);

  always_comb begin
    occ_p = occ_r - 2'(pop);
    sh[0] = pop ? q_r[1] : q_r[0];
    sh[1] = pop ? q_r[2] : q_r[1];
    sh[2] = q_r[2];
    for (int i = 0; i < 3; i++) begin
      if ((2'(i) == occ_p) && (push.cnt != 2'd0)) begin
        q_nxt[i] = push.a;
      end else if ((2'(i) == occ_p + 2'd1) && (push.cnt == 2'd2)) begin
        q_nxt[i] = push.b;
      end else begin
        q_nxt[i] = sh[i];
      end
    end
    occ_nxt = occ_p + push.cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 2'd0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  `PCME_ASSERT_IMPLY(a_push_room, push.cnt != 2'd0, occ_r <= 2'd1, "results pushed into a full queue")
  `PCME_ASSERT_NEXT(a_drain, pop && (push.cnt == 2'd0), occ_r == $past(occ_r) - 2'd1, "queue did not drain on pop")
  `PCME_ASSERT_NEXT(a_double_push, push.cnt == 2'd2, occ_r >= 2'd2, "double push lost a result")

endmodule

`default_nettype wire
